// ===== rtl/lbp_pkg.sv =====
// Package for the local binary pattern operator: widths, register indexes,
// shared structs and the uniform pattern label table.
// Depends on nothing; every other file of the block imports it.
package lbp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int MIN_DIM   = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    typedef enum logic [1:0] {
        REG_UNIFORM = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2
    } t_reg_idx;

    // Effective configuration, already clamped to the legal range.
    typedef struct packed {
        logic                uniform_mode;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_cfg;

    // Raster position of the pixel currently offered.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             emit;
        logic             frame_end;
    } t_pos;

    localparam int NUM_UNIFORM       = 58;
    localparam int NON_UNIFORM_LABEL = 58;
    localparam int LABEL_W           = 6;

    localparam logic [0:NUM_UNIFORM-1][7:0] UNIFORM_CODES = '{
        8'd0,   8'd16,  8'd8,   8'd4,   8'd2,   8'd1,   8'd128, 8'd64,  8'd32,
        8'd24,  8'd12,  8'd6,   8'd3,   8'd129, 8'd192, 8'd96,  8'd48,
        8'd56,  8'd28,  8'd14,  8'd7,   8'd131, 8'd193, 8'd224, 8'd112,
        8'd60,  8'd30,  8'd15,  8'd135, 8'd195, 8'd225, 8'd240, 8'd120,
        8'd124, 8'd62,  8'd31,  8'd143, 8'd199, 8'd227, 8'd241, 8'd248,
        8'd126, 8'd63,  8'd159, 8'd207, 8'd231, 8'd243, 8'd249, 8'd252,
        8'd254, 8'd127, 8'd191, 8'd223, 8'd239, 8'd247, 8'd251, 8'd253,
        8'd255
    };

    typedef logic [255:0][LABEL_W-1:0] t_label_lut;

    // Inverts the uniform code list into a 256-entry label table.
    function automatic t_label_lut f_build_label_lut();
        t_label_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = LABEL_W'(NON_UNIFORM_LABEL);
        end
        for (int k = 0; k < NUM_UNIFORM; k++) begin
            lut[UNIFORM_CODES[k]] = LABEL_W'(k);
        end
        return lut;
    endfunction

    localparam t_label_lut LABEL_LUT = f_build_label_lut();

endpackage

// ===== rtl/lbp_cfg_regs.sv =====
// Configuration registers of the LBP operator behind an APB-style port.
// Depends on lbp_pkg for register indexes, widths and the t_cfg struct.
module lbp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbp_pkg::DATA_W-1:0]   pwdata,
    output logic [lbp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output lbp_pkg::t_cfg                o_cfg
);
    import lbp_pkg::*;

    logic                r_uniform;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    t_reg_idx            w_idx;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform <= 1'b0;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_UNIFORM: r_uniform <= pwdata[0];
                REG_WIDTH:   r_width   <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:  r_height  <= pwdata[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_UNIFORM: prdata = DATA_W'(r_uniform);
            REG_WIDTH:   prdata = DATA_W'(r_width);
            REG_HEIGHT:  prdata = DATA_W'(r_height);
            default:     prdata = '0;
        endcase
    end

    // Out-of-range sizes are clamped here so that the datapath never sees them.
    always_comb begin
        o_cfg.uniform_mode = r_uniform;
        if (32'(r_width) < 32'(MIN_DIM)) begin
            o_cfg.width = WIDTH_W'(MIN_DIM);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            o_cfg.width = WIDTH_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end
        if (32'(r_height) < 32'(MIN_DIM)) begin
            o_cfg.height = HEIGHT_W'(MIN_DIM);
        end else begin
            o_cfg.height = r_height;
        end
    end

endmodule

// ===== rtl/lbp_raster_cnt.sv =====
// Column and row counters that track the raster position of incoming pixels.
// Depends on lbp_pkg for the t_cfg and t_pos structs.
module lbp_raster_cnt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lbp_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    output lbp_pkg::t_pos o_pos
);
    import lbp_pkg::*;

    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [COL_W-1:0]    n_col;
    logic [HEIGHT_W-1:0] n_row;
    logic                w_row_end;
    logic                w_frame_end;

    // A counter at or beyond the last column or row also ends it, which covers
    // a size reduced in the middle of a frame.
    assign w_row_end   = (32'(r_col) + 32'd1) >= 32'(i_cfg.width);
    assign w_frame_end = w_row_end && ((32'(r_row) + 32'd1) >= 32'(i_cfg.height));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = w_frame_end ? '0 : HEIGHT_W'(32'(r_row) + 32'd1);
            end else begin
                n_col = COL_W'(32'(r_col) + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col       = r_col;
    assign o_pos.emit      = (r_row >= HEIGHT_W'(2)) && (r_col >= COL_W'(2));
    assign o_pos.frame_end = w_frame_end;

endmodule

// ===== rtl/lbp_core.sv =====
// Line memory, 3x3 window and pattern datapath of the LBP operator.
// Depends on lbp_pkg for widths, structs and the uniform label table.
module lbp_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lbp_pkg::t_cfg             i_cfg,
    input  lbp_pkg::t_pos             i_pos,
    input  logic                      i_pix_valid,
    input  logic [lbp_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_pix_ready,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_pattern_code,
    output logic                      o_frame_last
);
    import lbp_pkg::*;

    // Each entry holds one column of the two stored lines: {older, newer}.
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_pix;
    t_pos               r_s1_pos;

    // Window columns: [0..2] left column, [3..5] middle column, top to bottom.
    logic [5:0][PIX_W-1:0] r_win;

    logic               r_out_valid;
    logic [7:0]         r_out_code;
    logic               r_out_last;

    logic               w_accept;
    logic               w_s1_adv;
    logic [PIX_W-1:0]   w_top;
    logic [PIX_W-1:0]   w_mid;
    logic [PIX_W-1:0]   w_ctr;
    logic [7:0]         w_raw;
    logic [7:0]         n_code;

    assign w_s1_adv    = r_s1_valid && (!r_s1_pos.emit || !r_out_valid || i_ready);
    assign o_pix_ready = !r_s1_valid || w_s1_adv;
    assign w_accept    = i_pix_valid && o_pix_ready;

    // Read at acceptance, write back when the item leaves stage one. The two
    // addresses in one cycle are adjacent, or last and first, so never collide.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_line_mem[i_pos.col];
        end
        if (w_s1_adv) begin
            r_line_mem[r_s1_pos.col] <= {w_mid, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix <= i_pixel;
            r_s1_pos <= i_pos;
        end
    end

    assign w_top = r_rd_data[2*PIX_W-1:PIX_W];
    assign w_mid = r_rd_data[PIX_W-1:0];
    assign w_ctr = r_win[4];

    always_comb begin
        w_raw[7] = r_win[0] >= w_ctr;
        w_raw[6] = r_win[3] >= w_ctr;
        w_raw[5] = w_top    >= w_ctr;
        w_raw[4] = w_mid    >= w_ctr;
        w_raw[3] = r_s1_pix >= w_ctr;
        w_raw[2] = r_win[5] >= w_ctr;
        w_raw[1] = r_win[2] >= w_ctr;
        w_raw[0] = r_win[1] >= w_ctr;
        n_code   = i_cfg.uniform_mode ? 8'(LABEL_LUT[w_raw]) : w_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_win <= {r_s1_pix, w_mid, w_top, r_win[5], r_win[4], r_win[3]};
            end
            if (w_s1_adv && r_s1_pos.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_pos.emit) begin
            r_out_code <= n_code;
            r_out_last <= r_s1_pos.frame_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pattern_code = r_out_code;
    assign o_frame_last   = r_out_last;

endmodule

// ===== rtl/lbp_image_operator.sv =====
// Top level of the streaming 8-neighbour local binary pattern operator.
// Depends on lbp_pkg, lbp_cfg_regs, lbp_raster_cnt and lbp_core.

// The block takes one 8-bit grey pixel per clock cycle in raster order and,
// for every pixel that is not on the first or last row or column, returns one
// 8-bit pattern code: each of the eight neighbours that is at least the centre
// (unsigned) sets a bit, upper-left in bit 7 and then clockwise to left in
// bit 0. With uniform mode set the code is replaced by its uniform label, 0 to
// 57 for the 58 uniform patterns and 58 for all others. The code for a centre
// pixel is delivered after the pixel below and to its right has been taken,
// and o_frame_last marks the final code of each frame; border pixels produce
// no output. Throughput is one pixel per cycle, sustained, as long as the
// output side takes results: the rate is set by the line memory, which holds
// both stored lines side by side in one entry per column and so needs exactly
// one read and one write per pixel. The pixel completing a window is held in
// stage one, and its code is loaded into the output register when that pixel
// leaves stage one, then offered until it is taken. The line
// memory has no reset and needs no clearing pass; its first two rows are
// never used for a result. Image width (3 to 1024) and height (3 to 65535)
// are clamped into range, and registers should only be written while no
// request is in flight. Register map: 0x0 uniform mode, 0x4 width, 0x8 height.
module lbp_image_operator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbp_pkg::DATA_W-1:0]   pwdata,
    output logic [lbp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_pattern_code,
    output logic                         o_frame_last
);
    import lbp_pkg::*;

    t_cfg w_cfg;
    t_pos w_pos;
    logic w_accept;

    // The raster counters move with every accepted pixel request.
    assign w_accept = i_valid && o_ready;

    lbp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lbp_raster_cnt u_raster_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_accept (w_accept),
        .o_pos    (w_pos)
    );

    // The core owns the line memory, the window and the output register,
    // and decides when a new pixel can enter.
    lbp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_pos          (w_pos),
        .i_pix_valid    (i_valid),
        .i_pixel        (i_pixel),
        .o_pix_ready    (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pattern_code (o_pattern_code),
        .o_frame_last   (o_frame_last)
    );

endmodule

// ===== rtl/lbp_checker.sv =====
// Port-level checker for the LBP operator, bound to the top level.
// Depends on lbp_pkg for the register map and on lbp_image_operator.
module lbp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [lbp_pkg::PADDR_W-1:0]  paddr,
    input logic [lbp_pkg::DATA_W-1:0]   pwdata,
    input logic [lbp_pkg::DATA_W-1:0]   prdata,
    input logic                         pready,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [7:0]                   o_pattern_code,
    input logic                         o_frame_last
);
    import lbp_pkg::*;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR = {REG_WIDTH, 2'b00};

    // A result can only appear after a pixel request was taken and passed stage one.
    a_out_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result appeared without a preceding pixel request");

    // With the output register empty the block must always take a pixel.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while no result was pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_pattern_code) && $stable(o_frame_last)))
        else $error("pending result changed before it was taken");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr == WIDTH_ADDR) |=>
            (paddr != WIDTH_ADDR || prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0])))
        else $error("width register read back differs from the value written");

endmodule

bind lbp_image_operator lbp_checker u_lbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pattern_code (o_pattern_code),
    .o_frame_last   (o_frame_last)
);

// ===== tb/lbp_code_checker.sv =====
`timescale 1ns / 100ps
// Checker for the local binary pattern operator: follows register writes and
// pixel requests, predicts each pattern code and compares what comes out.
// Depends on lbp_pkg for the bus widths and the register indexes.
module lbp_code_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lbp_pkg::PADDR_W-1:0] paddr,
    input  logic [lbp_pkg::DATA_W-1:0]  pwdata,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [7:0]                  i_pixel,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [7:0]                  o_pattern_code,
    input  logic                        o_frame_last,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_codes_checked
);
    import lbp_pkg::*;

    localparam logic [7:0] LABEL_ALL_SET = 8'd57;
    localparam logic [7:0] LABEL_OTHER   = 8'd58;

    typedef struct packed {
        logic [7:0] code;
        logic       frame_last;
    } t_lbp_result;

    // Register copies, as written, before clamping.
    logic                cfg_uniform;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    // Two stored lines, the older above the newer, and the two previous
    // columns of the window (top, middle, bottom).
    logic [7:0] line_old [MAX_WIDTH];
    logic [7:0] line_new [MAX_WIDTH];
    logic [7:0] left_col [3];
    logic [7:0] mid_col  [3];
    int         col_pos;
    int         row_pos;

    t_lbp_result expected_codes [$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_codes_checked = 0;
    end

    // Uniform patterns with n set bits are a run of n ones, numbered from the
    // starting position below and then rotated right one place at a time.
    function automatic logic [7:0] uniform_label(input logic [7:0] code);
        int         ones;
        logic [7:0] base;
        logic [7:0] rot;
        ones = $countones(code);
        if (ones == 0) return 8'd0;
        if (ones == 8) return LABEL_ALL_SET;
        base = 8'((1 << ones) - 1) << ((9 - ones) / 2);
        for (int k = 0; k < 8; k++) begin
            rot = (base >> k) | (base << (8 - k));
            if (rot == code) return 8'(1 + 8 * (ones - 1) + k);
        end
        return LABEL_OTHER;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic shift_in_pixel(input logic [7:0] pix);
        int          w_eff;
        int          h_eff;
        int          col;
        logic [7:0]  above;
        logic [7:0]  beside;
        logic [7:0]  ctr;
        logic [7:0]  code;
        logic        row_done;
        logic        frame_done;
        t_lbp_result res;
        w_eff = (cfg_width < MIN_DIM) ? MIN_DIM :
                (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        h_eff = (cfg_height < MIN_DIM) ? MIN_DIM : int'(cfg_height);
        col = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        above = line_old[col];
        beside = line_new[col];
        row_done = (col_pos + 1) >= w_eff;
        frame_done = row_done && (row_pos + 1) >= h_eff;
        if (row_pos >= 2 && col_pos >= 2) begin
            ctr = mid_col[1];
            code = {left_col[0] >= ctr, mid_col[0] >= ctr, above >= ctr, beside >= ctr,
                    pix >= ctr, mid_col[2] >= ctr, left_col[2] >= ctr, left_col[1] >= ctr};
            if (cfg_uniform) code = uniform_label(code);
            res.code = code;
            res.frame_last = frame_done;
            expected_codes.insert(expected_codes.size(), res);
        end
        for (int i = 0; i < 3; i++) left_col[i] = mid_col[i];
        mid_col[0] = above;
        mid_col[1] = beside;
        mid_col[2] = pix;
        line_old[col] = beside;
        line_new[col] = pix;
        if (row_done) begin
            col_pos = 0;
            row_pos = frame_done ? 0 : (row_pos + 1) % 65536;
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_uniform = 1'b0;
            cfg_width = WIDTH_RESET;
            cfg_height = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                line_old[i] = '0;
                line_new[i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                left_col[i] = '0;
                mid_col[i] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            expected_codes.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("code %0d with nothing expected",
                                              o_pattern_code));
                end else begin
                    t_lbp_result want;
                    want = expected_codes.pop_front();
                    o_codes_checked++;
                    if (o_pattern_code !== want.code)
                        report_mismatch($sformatf("pattern code %0d, expected %0d",
                                                  o_pattern_code, want.code));
                    if (o_frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame last %0b, expected %0b",
                                                  o_frame_last, want.frame_last));
                end
            end
            if (i_valid && o_ready) shift_in_pixel(i_pixel);
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_UNIFORM: cfg_uniform = pwdata[0];
                    REG_WIDTH:   cfg_width = pwdata[WIDTH_W-1:0];
                    REG_HEIGHT:  cfg_height = pwdata[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_codes.size();
    end

endmodule

// ===== tb/lbp_image_operator_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the local binary pattern operator: clock, reset, register
// writes, pixel requests and the result side's stalls, plus the final verdict.
// Depends on lbp_pkg, lbp_image_operator and lbp_code_checker.
module lbp_image_operator_tb;
    import lbp_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int DIRECTED_PX   = 18;
    localparam int RANDOM_PX     = 480;
    localparam int SETTLE_CYCLES = 4;
    localparam int CUT_WIDTH     = 40;

    // Pixel content of a frame: plain noise, only the two extremes, or a
    // narrow band of grey levels so that neighbours often equal the centre.
    typedef enum int {
        STYLE_NOISE,
        STYLE_BINARY,
        STYLE_FLAT
    } t_pixel_style;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_pixel = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [7:0]          o_pattern_code;
    logic                o_frame_last;

    int   fail_count;
    int   pending;
    int   codes_checked;
    int   pixels_sent = 0;
    int   reg_writes = 0;
    int   idle_cycles = 0;
    int   frame_w;
    int   frame_h;
    logic steady = 1'b0;

    lbp_image_operator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pattern_code (o_pattern_code),
        .o_frame_last   (o_frame_last)
    );

    lbp_code_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel         (i_pixel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pattern_code  (o_pattern_code),
        .o_frame_last    (o_frame_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_codes_checked (codes_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls about one cycle in ten, except during the steady
    // stretch, where it takes every code at once.
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // Watchdog: any accepted request, accepted code or register access counts
    // as progress. A run that stands still for too long is a failure.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_pixel(input t_pixel_style style);
        case (style)
            STYLE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            STYLE_FLAT:   return 8'(126 + $urandom_range(0, 3));
            default:      return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One pixel request. Valid may drop for a random gap first; once raised
    // it holds, with the pixel unchanged, until the block takes it.
    task automatic push_pixel(input logic [7:0] pix);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input t_pixel_style style);
        for (int i = 0; i < count; i++) push_pixel(pick_pixel(style));
    endtask

    // A 3x3 frame given as one vector, first pixel in the top byte.
    task automatic send_tiny_frame(input logic [71:0] pixels);
        for (int i = 0; i < 9; i++) push_pixel(pixels[71 - 8 * i -: 8]);
    endtask

    // Registers are only touched with nothing in flight: stop sending, let
    // every predicted code come out, then allow the pipeline to settle, since
    // border pixels may still be moving through without producing a code.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the access edge.
    task automatic reg_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
    endtask

    // New random settings for the next frames. Now and then a width or height
    // below the minimum is written, which the block must treat as three. The
    // upper bits of the mode word are random and must be ignored.
    task automatic reconfigure_random();
        int w_val;
        int h_val;
        wait_drained();
        w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
        h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        reg_write(REG_UNIFORM, $urandom());
        reg_write(REG_WIDTH, DATA_W'(w_val));
        reg_write(REG_HEIGHT, DATA_W'(h_val));
        frame_w = (w_val < MIN_DIM) ? MIN_DIM : w_val;
        frame_h = (h_val < MIN_DIM) ? MIN_DIM : h_val;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames. The first is a plain code with both pixel extremes
        // around a centre that ties with one neighbour. The second runs in
        // uniform mode with width and height written below the minimum, and a
        // checkerboard window, which is not a uniform pattern.
        reg_write(REG_WIDTH, DATA_W'(3));
        reg_write(REG_HEIGHT, DATA_W'(3));
        send_tiny_frame({8'd0,   8'd255, 8'd0,
                         8'd255, 8'd128, 8'd127,
                         8'd128, 8'd0,   8'd255});
        wait_drained();
        reg_write(REG_UNIFORM, 32'hFFFF_FFFF);
        reg_write(REG_WIDTH, DATA_W'(1));
        reg_write(REG_HEIGHT, DATA_W'(0));
        send_tiny_frame({8'd255, 8'd0,   8'd255,
                         8'd0,   8'd100, 8'd0,
                         8'd255, 8'd0,   8'd255});

        // Random small frames, mostly back to back, with new settings about
        // one frame in three. Part of the way through, neither side idles.
        reconfigure_random();
        while (pixels_sent < DIRECTED_PX + RANDOM_PX) begin
            steady = (pixels_sent >= 300 && pixels_sent < 450);
            if ($urandom_range(0, 2) == 0) reconfigure_random();
            send_pixels(frame_w * frame_h, t_pixel_style'($urandom_range(0, 2)));
        end
        steady = 1'b0;

        // A wider and very tall frame. Two full lines and part of a third go
        // in, then the frame is cut short by shrinking both sizes while the
        // counters lie beyond the new last column and on the new last row, so the next pixel
        // closes the frame. A small frame at the new size follows.
        wait_drained();
        reg_write(REG_UNIFORM, $urandom());
        reg_write(REG_WIDTH, DATA_W'(CUT_WIDTH));
        reg_write(REG_HEIGHT, DATA_W'(65535));
        send_pixels(2 * CUT_WIDTH + 20, STYLE_NOISE);
        wait_drained();
        reg_write(REG_WIDTH, DATA_W'(10));
        reg_write(REG_HEIGHT, DATA_W'(3));
        send_pixels(1, STYLE_NOISE);
        send_pixels(30, STYLE_FLAT);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("%0d pixels sent and %0d register writes, widths 3 to 40, plain and uniform",
                 pixels_sent, reg_writes);
        $display("%0d pattern codes compared, %0d mismatches", codes_checked, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lbp_pkg.sv
rtl/lbp_cfg_regs.sv
rtl/lbp_raster_cnt.sv
rtl/lbp_core.sv
rtl/lbp_image_operator.sv
rtl/lbp_checker.sv
tb/lbp_code_checker.sv
tb/lbp_image_operator_tb.sv
